### rtl/ccp_pkg.sv
package ccp_pkg;

  localparam int DEPTH_ENTRIES_DEF = 65536;
  localparam int DEPTH_BITS_DEF    = 32;

  localparam int IN_TDATA_W  = 120;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;

  localparam int CURSOR_W   = 33;
  localparam int EXTENT_W   = 17;
  localparam int EXTENT_MAX = 131071;
  localparam int CMD_ADDR_W = 24;
  localparam int CMD_CNT_W  = 25;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_CIGAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [3:0] OP_M    = 4'd0;
  localparam logic [3:0] OP_D    = 4'd2;
  localparam logic [3:0] OP_N    = 4'd3;
  localparam logic [3:0] OP_EQ   = 4'd7;
  localparam logic [3:0] OP_X    = 4'd8;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INC,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [CMD_ADDR_W-1:0] addr;
    logic [CMD_CNT_W-1:0]  cnt;
    logic                  order_error;
    logic                  out_of_range;
    logic [EXTENT_W-1:0]   extent;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_INC,
    BK_READ
  } bk_state_t;

endpackage

### rtl/ccp_front.sv
module ccp_front #(
  parameter int DEPTH_ENTRIES = ccp_pkg::DEPTH_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear_done,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ccp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [ccp_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            push_valid,
  input  logic                            push_ready,
  output ccp_pkg::cmd_t                   push_cmd
);

  localparam logic [33:0] DE34     = 34'(DEPTH_ENTRIES);
  localparam logic [33:0] EXT34    = 34'(ccp_pkg::EXTENT_MAX);
  localparam logic [32:0] CURS_MAX = '1;

  logic                               hold_valid_r, hold_valid_nxt;
  logic [ccp_pkg::IN_TDATA_W-1:0]     hold_data_r;
  logic [ccp_pkg::IN_TUSER_W-1:0]     hold_req_r;

  logic [31:0]                        prev_ref_r, prev_ref_nxt;
  logic [31:0]                        prev_start_r, prev_start_nxt;
  logic                               have_prev_r, have_prev_nxt;
  logic [ccp_pkg::CURSOR_W-1:0]       cursor_r, cursor_nxt;
  logic                               skip_r, skip_nxt;
  logic                               active_r, active_nxt;
  logic [ccp_pkg::EXTENT_W-1:0]       extent_r, extent_nxt;

  logic [31:0]                        f_ref_id;
  logic [31:0]                        f_start;
  logic                               f_mapped;
  logic [3:0]                         f_op;
  logic [27:0]                        f_len;
  logic [15:0]                        f_addr;

  logic                               in_acc;
  logic                               push;
  logic [33:0]                        hi;
  logic [32:0]                        hi_sat;
  logic [33:0]                        top;
  logic [33:0]                        span;
  logic [33:0]                        ext_cand;
  logic                               span_ok;
  logic                               is_match;
  logic                               order_ok;

  assign f_ref_id = hold_data_r[31:0];
  assign f_start  = hold_data_r[63:32];
  assign f_mapped = hold_data_r[64];
  assign f_op     = hold_data_r[68:65];
  assign f_len    = hold_data_r[96:69];
  assign f_addr   = hold_data_r[112:97];

  assign in_tready  = !hold_valid_r && clear_done;
  assign in_acc     = in_tvalid && in_tready;
  assign push_valid = hold_valid_r;
  assign push       = hold_valid_r && push_ready;

  assign hi       = {1'b0, cursor_r} + 34'(f_len);
  assign hi_sat   = hi[33] ? CURS_MAX : hi[32:0];
  assign top      = (hi > DE34) ? DE34 : hi;
  assign span_ok  = {1'b0, cursor_r} < top;
  assign span     = top - {1'b0, cursor_r};
  assign ext_cand = (top > EXT34) ? EXT34 : top;
  assign is_match = (f_op == ccp_pkg::OP_M) || (f_op == ccp_pkg::OP_EQ) ||
                    (f_op == ccp_pkg::OP_X);
  assign order_ok = !have_prev_r || (f_ref_id > prev_ref_r) ||
                    ((f_ref_id == prev_ref_r) && (f_start >= prev_start_r));

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_acc) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    prev_ref_nxt   = prev_ref_r;
    prev_start_nxt = prev_start_r;
    have_prev_nxt  = have_prev_r;
    cursor_nxt     = cursor_r;
    skip_nxt       = skip_r;
    active_nxt     = active_r;
    extent_nxt     = extent_r;
    push_cmd       = '0;
    push_cmd.kind  = ccp_pkg::CMD_NONE;

    unique case (hold_req_r)
      ccp_pkg::REQ_START: begin
        if (order_ok) begin
          prev_ref_nxt   = f_ref_id;
          prev_start_nxt = f_start;
          have_prev_nxt  = 1'b1;
          cursor_nxt     = {1'b0, f_start};
          skip_nxt       = 1'b1;
          active_nxt     = f_mapped;
        end else begin
          push_cmd.order_error = 1'b1;
          active_nxt           = 1'b0;
        end
      end
      ccp_pkg::REQ_CIGAR: begin
        if (active_r) begin
          if (is_match) begin
            skip_nxt              = 1'b0;
            push_cmd.out_of_range = (f_len != 28'd0) && (hi > DE34);
            if (span_ok) begin
              push_cmd.kind = ccp_pkg::CMD_INC;
              push_cmd.addr = cursor_r[ccp_pkg::CMD_ADDR_W-1:0];
              push_cmd.cnt  = span[ccp_pkg::CMD_CNT_W-1:0];
              if (ext_cand > 34'(extent_r)) begin
                extent_nxt = ext_cand[ccp_pkg::EXTENT_W-1:0];
              end
            end
            cursor_nxt = hi_sat;
          end else if (!skip_r && ((f_op == ccp_pkg::OP_D) || (f_op == ccp_pkg::OP_N))) begin
            cursor_nxt = hi_sat;
          end
        end
      end
      ccp_pkg::REQ_READ: begin
        if (34'(f_addr) < DE34) begin
          push_cmd.kind = ccp_pkg::CMD_READ;
          push_cmd.addr = ccp_pkg::CMD_ADDR_W'(f_addr);
        end
      end
      default: begin
      end
    endcase
    push_cmd.extent = extent_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_data_r <= in_tdata;
      hold_req_r  <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      prev_ref_r   <= '0;
      prev_start_r <= '0;
      have_prev_r  <= 1'b0;
      cursor_r     <= '0;
      skip_r       <= 1'b1;
      active_r     <= 1'b0;
      extent_r     <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (push) begin
        prev_ref_r   <= prev_ref_nxt;
        prev_start_r <= prev_start_nxt;
        have_prev_r  <= have_prev_nxt;
        cursor_r     <= cursor_nxt;
        skip_r       <= skip_nxt;
        active_r     <= active_nxt;
        extent_r     <= extent_nxt;
      end
    end
  end

endmodule

### rtl/ccp_queue.sv
module ccp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  ccp_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output ccp_pkg::cmd_t pop_cmd
);

  localparam int PW = $clog2(ccp_pkg::QUEUE_DEPTH);

  ccp_pkg::cmd_t   slot_r [ccp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [PW:0]     count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count_r != (PW+1)'(ccp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/ccp_back.sv
module ccp_back #(
  parameter int DEPTH_ENTRIES = ccp_pkg::DEPTH_ENTRIES_DEF,
  parameter int DEPTH_BITS    = ccp_pkg::DEPTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  input  ccp_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  output logic                             clear_done,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ccp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int AW = $clog2(DEPTH_ENTRIES);

  logic [DEPTH_BITS-1:0]           mem [DEPTH_ENTRIES];
  logic [DEPTH_BITS-1:0]           rdata_r;

  ccp_pkg::bk_state_t              state_r, state_nxt;
  logic [AW-1:0]                   clr_idx_r, clr_idx_nxt;
  logic [AW-1:0]                   wr_addr_r, wr_addr_nxt;
  logic [AW:0]                     left_r, left_nxt;
  logic                            res_err_r, res_err_nxt;
  logic                            res_oor_r, res_oor_nxt;
  logic [ccp_pkg::EXTENT_W-1:0]    res_ext_r, res_ext_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [ccp_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                            out_free;
  logic                            out_load;
  logic                            ld_err;
  logic                            ld_oor;
  logic [ccp_pkg::EXTENT_W-1:0]    ld_ext;
  logic [31:0]                     ld_depth;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [AW-1:0]                   mem_raddr;
  logic [DEPTH_BITS-1:0]           mem_wdata;

  assign out_free   = !out_valid_r || out_tready;
  assign clear_done = state_r != ccp_pkg::BK_CLEAR;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    wr_addr_nxt = wr_addr_r;
    left_nxt    = left_r;
    res_err_nxt = res_err_r;
    res_oor_nxt = res_oor_r;
    res_ext_nxt = res_ext_r;
    cmd_pop     = 1'b0;
    out_load    = 1'b0;
    ld_err      = res_err_r;
    ld_oor      = res_oor_r;
    ld_ext      = res_ext_r;
    ld_depth    = '0;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_r;
    mem_raddr   = wr_addr_r;
    mem_wdata   = '0;

    unique case (state_r)
      ccp_pkg::BK_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(DEPTH_ENTRIES - 1)) begin
          state_nxt = ccp_pkg::BK_IDLE;
        end
      end
      ccp_pkg::BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop     = 1'b1;
          res_err_nxt = cmd.order_error;
          res_oor_nxt = cmd.out_of_range;
          res_ext_nxt = cmd.extent;
          unique case (cmd.kind)
            ccp_pkg::CMD_INC: begin
              mem_raddr   = cmd.addr[AW-1:0];
              wr_addr_nxt = cmd.addr[AW-1:0];
              left_nxt    = cmd.cnt[AW:0] - 1'b1;
              state_nxt   = ccp_pkg::BK_INC;
            end
            ccp_pkg::CMD_READ: begin
              mem_raddr = cmd.addr[AW-1:0];
              mem_we    = 1'b1;
              mem_waddr = cmd.addr[AW-1:0];
              state_nxt = ccp_pkg::BK_READ;
            end
            default: begin
              out_load = 1'b1;
              ld_err   = cmd.order_error;
              ld_oor   = cmd.out_of_range;
              ld_ext   = cmd.extent;
            end
          endcase
        end
      end
      ccp_pkg::BK_INC: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr_r;
        mem_wdata = (rdata_r == '1) ? rdata_r : rdata_r + 1'b1;
        if (left_r != '0) begin
          mem_raddr   = wr_addr_r + 1'b1;
          wr_addr_nxt = wr_addr_r + 1'b1;
          left_nxt    = left_r - 1'b1;
        end else begin
          out_load  = 1'b1;
          state_nxt = ccp_pkg::BK_IDLE;
        end
      end
      ccp_pkg::BK_READ: begin
        out_load  = 1'b1;
        ld_depth  = 32'(rdata_r);
        state_nxt = ccp_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = ccp_pkg::BK_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // depth store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {5'b0, ld_ext, ld_depth, ld_oor, ld_err};
    end
    wr_addr_r <= wr_addr_nxt;
    left_r    <= left_nxt;
    res_err_r <= res_err_nxt;
    res_oor_r <= res_oor_nxt;
    res_ext_r <= res_ext_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccp_pkg::BK_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/cigar_coverage_pileup_top.sv
// channel   dir  handshake                 payload
// in_*      in   in_tvalid / in_tready     in_tuser: req_type; in_tdata: alignment, cigar op, addr
// out_*     out  out_tvalid / out_tready   out_tdata: flags, depth, coverage extent
//
// the front holds one word at a time and takes no new word until it is pushed into a four-entry command queue
// a match op holds the depth store port until every in-range base that it covers is incremented
// a read-and-clear goes through BK_READ; any other word without a match answers from BK_IDLE
// after reset every depth store entry is swept to zero while in_tready is low
// a stalled output register holds the back end; the queue keeps the front taking words until it is full
module cigar_coverage_pileup_top #(
  parameter int DEPTH_ENTRIES = ccp_pkg::DEPTH_ENTRIES_DEF,
  parameter int DEPTH_BITS    = ccp_pkg::DEPTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // ref_id, start_pos, is_mapped, op_code, op_length, read_addr
  input  logic [ccp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type
  input  logic [ccp_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // order_error, out_of_range, depth_value, coverage_extent
  output logic [ccp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  ccp_pkg::cmd_t push_cmd;
  ccp_pkg::cmd_t pop_cmd;
  logic          push_valid;
  logic          push_ready;
  logic          pop_valid;
  logic          pop;
  logic          clear_done;

  ccp_front #(
    .DEPTH_ENTRIES (DEPTH_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_done (clear_done),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ccp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  ccp_back #(
    .DEPTH_ENTRIES (DEPTH_ENTRIES),
    .DEPTH_BITS    (DEPTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (pop_valid),
    .cmd        (pop_cmd),
    .cmd_pop    (pop),
    .clear_done (clear_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/ccp_checker.sv
module ccp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ccp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                          in_acc;
  logic                          out_acc;
  logic [3:0]                    pend_r, pend_nxt;
  logic [ccp_pkg::EXTENT_W-1:0]  last_ext_r;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign pend_nxt = pend_r + 4'(in_acc) - 4'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      last_ext_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (out_acc) begin
        last_ext_r <= out_tdata[50:34];
      end
    end
  end

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // no word without an accepted input word before it
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 4'd0)
    else $error("output word without pending input word");

  // coverage extent never shrinks between reset points
  a_ext_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> out_tdata[50:34] >= last_ext_r)
    else $error("coverage extent went down");

  // order error and out of range come from different word kinds
  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("order_error and out_of_range both set");

  // reset empties the output and starts the clearing sweep
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("ports active right after reset");

endmodule

bind cigar_coverage_pileup_top ccp_checker u_ccp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
